// ===== hdl/vdt_pkg.sv =====
// ----------------------------------------------------------------------------
// vdt_pkg
// Types and helpers shared by the vertex de-duplication table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vdt_pkg;

	localparam int unsigned IdxW = 8;

	typedef struct packed {
		logic        start_new;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] nrm_x;
		logic [31:0] nrm_y;
		logic [31:0] nrm_z;
	} vdt_in_t;

	typedef struct packed {
		logic [IdxW-1:0] slot_index;
		logic            is_new;
		logic            overflow;
	} vdt_out_t;

	function automatic logic is_nan32(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic feq32(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (is_nan32(a) || is_nan32(b)) begin
			r = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			r = 1'b1;
		end else begin
			r = (a == b);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/vdt_front.sv =====
// ----------------------------------------------------------------------------
// vdt_front
// Input stage: accepts vertex beats into a two-entry queue for the search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vdt_front
	import vdt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vdt_in_t in_data,
	input  wire logic    in_valid,
	output logic         in_ready,
	output vdt_in_t      q_data,
	output logic         q_valid,
	input  wire logic    q_ready
);
	vdt_in_t   buf_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/vdt_back.sv =====
// ----------------------------------------------------------------------------
// vdt_back
// Search unit: reads then compares stored entries one at a time, then matches, appends or flags overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vdt_back
	import vdt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vdt_in_t q_data,
	input  wire logic    q_valid,
	output logic         q_ready,
	output vdt_out_t     out_data,
	output logic         out_valid,
	input  wire logic    out_ready
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [255:0]  mem_q [TABLE_DEPTH];
	logic [255:0]  rd_q;
	logic [CW-1:0] count_q, n_q, ptr_q;
	vdt_in_t       cur_q;
	logic          hit;

	assign q_ready = (state_q == S_IDLE);

	assign hit = feq32(rd_q[31:0], cur_q.pos_x)     && feq32(rd_q[63:32], cur_q.pos_y)
		&& feq32(rd_q[95:64], cur_q.pos_z)   && feq32(rd_q[127:96], cur_q.tex_u)
		&& feq32(rd_q[159:128], cur_q.tex_v) && feq32(rd_q[191:160], cur_q.nrm_x)
		&& feq32(rd_q[223:192], cur_q.nrm_y) && feq32(rd_q[255:224], cur_q.nrm_z);

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_q <= mem_q[ptr_q[AW-1:0]];
		end
		if ((state_q == S_DONE) && (ptr_q == n_q) && (n_q != Full)) begin
			mem_q[n_q[AW-1:0]] <= {cur_q.nrm_z, cur_q.nrm_y, cur_q.nrm_x, cur_q.tex_v,
				cur_q.tex_u, cur_q.pos_z, cur_q.pos_y, cur_q.pos_x};
		end
		if (q_valid && q_ready) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			n_q       <= '0;
			ptr_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			if (out_valid && out_ready && (state_q != S_DONE)) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						n_q     <= q_data.start_new ? '0 : count_q;
						ptr_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= (ptr_q == n_q) ? S_DONE : S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						if (ptr_q != n_q) begin
							out_data <= '{slot_index: IdxW'(ptr_q), is_new: 1'b0,
								overflow: 1'b0};
							count_q  <= n_q;
						end else if (n_q == Full) begin
							out_data <= '{slot_index: '0, is_new: 1'b0, overflow: 1'b1};
							count_q  <= n_q;
						end else begin
							out_data <= '{slot_index: IdxW'(n_q), is_new: 1'b1,
								overflow: 1'b0};
							count_q  <= n_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/vertex_dedup_table_core.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_table_core
// Vertex de-duplication table with linear search.
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one vertex beat (eight IEEE single bit patterns and
// a start flag); out_valid/out_ready carry one result beat per vertex: the
// entry index, a new-entry flag and an overflow flag.
// A two-beat input queue lets the next vertex be taken while the search unit
// works. The search reads the stored entries one at a time from a single-port
// table memory, each read followed by a compare, walking up to n entries
// where n is the live entry count (up to TABLE_DEPTH); a hit ends it early.
// Reset empties the table (entry count zero) and drops queued beats; the
// table memory is not cleared, only entries below the count are read.
// A stalled receiver holds the result register; the search unit waits with
// its finished result, and the input queue fills then deasserts in_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vertex_dedup_table_core
	import vdt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vdt_in_t in_data,
	input  wire logic    in_valid,
	output logic         in_ready,
	output vdt_out_t     out_data,
	output logic         out_valid,
	input  wire logic    out_ready
);
	vdt_in_t q_data;
	logic    q_valid, q_ready;

	vdt_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.q_data, .q_valid, .q_ready
	);

	vdt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .q_data, .q_valid, .q_ready,
		.out_data, .out_valid, .out_ready
	);

	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.overflow && out_data.is_new))
		else $error("overflow and new entry together");
	a_ovf_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.overflow) |-> (out_data.slot_index == '0))
		else $error("overflow with nonzero index");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped while stalled");
endmodule
`default_nettype wire
